FILE: design/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types for the handheld console bus decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // region codes reported with every result
    typedef enum logic [2:0] {
        REGION_ROM  = 3'd0,
        REGION_VRAM = 3'd1,
        REGION_WRAM = 3'd2,
        REGION_IO   = 3'd3,
        REGION_HRAM = 3'd4,
        REGION_IE   = 3'd5,
        REGION_NONE = 3'd6
    } region_t;

    // bus access kind
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // decoded access held between the input and the result register
    typedef struct packed {
        logic       is_write;
        region_t    region;
        logic       is_dma;
        logic [7:0] rom_byte;
        logic [7:0] ie_byte;
    } stage_t;

endpackage

FILE: design/hcbd_ram.sv
// ----------------------------------------------------------------------------
// hcbd_ram
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module hcbd_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hcbd_io_file.sv
// ----------------------------------------------------------------------------
// hcbd_io_file
// 128-byte I/O register file; entries not yet written read as zero.
// ----------------------------------------------------------------------------
module hcbd_io_file (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       we,
    input  logic       re,
    input  logic [6:0] addr,
    input  logic [7:0] wdata,
    output logic [7:0] rdata
);

    localparam int IO_BYTES = 128;

    logic [IO_BYTES-1:0] valid_reg;
    logic                valid_q_reg;
    logic [7:0]          ram_q;

    // byte storage
    hcbd_ram #(
        .DEPTH (IO_BYTES),
        .WIDTH (8),
        .AW    (7)
    ) u_io_ram (
        .clk   (clk),
        .we    (we),
        .re    (re),
        .addr  (addr),
        .wdata (wdata),
        .rdata (ram_q)
    );

    // written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (re)
            begin
                valid_q_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = valid_q_reg ? ram_q : 8'h00;

endmodule

FILE: design/hcbd_result.sv
// ----------------------------------------------------------------------------
// hcbd_result
// Read data selection and the result register of the master side.
// ----------------------------------------------------------------------------
module hcbd_result (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hcbd_pkg::stage_t  stage,
    input  logic [7:0]        vram_q,
    input  logic [7:0]        wram_q,
    input  logic [7:0]        io_q,
    input  logic [7:0]        hram_q,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // read_data
    output logic [2:0]        m_tuser    // region
);

    logic [7:0] rd_next;
    logic [7:0] rd_reg;
    logic [2:0] region_reg;
    logic       valid_reg;

    // pick the byte for this access
    always_comb
    begin
        rd_next = 8'h00;
        if (!stage.is_write)
        begin
            case (stage.region)
                hcbd_pkg::REGION_ROM:  rd_next = stage.rom_byte;
                hcbd_pkg::REGION_VRAM: rd_next = vram_q;
                hcbd_pkg::REGION_WRAM: rd_next = wram_q;
                hcbd_pkg::REGION_IO:   rd_next = stage.is_dma ? 8'hff : io_q;
                hcbd_pkg::REGION_HRAM: rd_next = hram_q;
                hcbd_pkg::REGION_IE:   rd_next = stage.ie_byte;
                default:               rd_next = 8'h00;
            endcase
        end
    end

    assign out_free = !valid_reg || m_tready;

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg     <= rd_next;
            region_reg <= stage.region;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = rd_reg;
    assign m_tuser  = region_reg;

endmodule

FILE: design/handheld_console_bus_decoder_top.sv
// ----------------------------------------------------------------------------
// handheld_console_bus_decoder_top
// Decodes one bus access per item against the console memory map.
//
//   channel   dir  tdata (low bit up)                     tuser
//   s_*       in   address, write_data, rom_byte          opcode
//   m_*       out  read_data                              region
//
// Decode stage, then result register; one item per cycle while m_tready is high;
// the single-port memories are read or written once per item at acceptance.
// No clearing pass after reset: the I/O file uses per-entry written flags.
// A stalled result holds the decode stage; input waits only when both are full.
// ----------------------------------------------------------------------------
module handheld_console_bus_decoder_top #(
    parameter int WORK_RAM_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address, write_data, rom_byte
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data
    output logic [2:0]  m_tuser    // region
);

    localparam int VRAM_BYTES = 8192;
    localparam int HRAM_BYTES = 127;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int WRAM_AW    = $clog2(WORK_RAM_BYTES);
    localparam int HRAM_AW    = $clog2(HRAM_BYTES);
    localparam logic [15:0] ADDR_LY  = 16'hff44;
    localparam logic [15:0] ADDR_DMA = 16'hff46;

    logic [15:0]          address;
    logic [7:0]           write_data;
    logic                 is_write;
    logic                 accept;
    logic                 advance;
    logic                 out_free;
    hcbd_pkg::region_t    region;
    hcbd_pkg::stage_t     stage_next;
    hcbd_pkg::stage_t     stage_reg;
    logic                 stage_valid_reg;
    logic [7:0]           ie_reg;
    logic [7:0]           vram_q;
    logic [7:0]           wram_q;
    logic [7:0]           io_q;
    logic [7:0]           hram_q;
    logic                 io_we;
    logic [7:0]           io_wdata;

    assign address    = s_tdata[15:0];
    assign write_data = s_tdata[23:16];
    assign is_write   = (hcbd_pkg::op_t'(s_tuser[0]) == hcbd_pkg::OP_WRITE);

    // handshake
    assign advance  = stage_valid_reg && out_free;
    assign s_tready = !stage_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // address decode
    always_comb
    begin
        case (address) inside
            [16'h0000:16'h7fff]: region = hcbd_pkg::REGION_ROM;
            [16'h8000:16'h9fff]: region = hcbd_pkg::REGION_VRAM;
            [16'hc000:16'hdfff]: region = hcbd_pkg::REGION_WRAM;
            [16'hff00:16'hff7f]: region = hcbd_pkg::REGION_IO;
            [16'hff80:16'hfffe]: region = hcbd_pkg::REGION_HRAM;
            16'hffff:            region = hcbd_pkg::REGION_IE;
            default:             region = hcbd_pkg::REGION_NONE;
        endcase
    end

    always_comb
    begin
        stage_next.is_write = is_write;
        stage_next.region   = region;
        stage_next.is_dma   = (address == ADDR_DMA);
        stage_next.rom_byte = s_tdata[31:24];
        stage_next.ie_byte  = ie_reg;
    end

    // decode stage valid and interrupt enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            ie_reg          <= 8'h00;
        end
        else
        begin
            if (s_tready)
            begin
                stage_valid_reg <= s_tvalid;
            end
            if (accept && is_write && region == hcbd_pkg::REGION_IE)
            begin
                ie_reg <= write_data;
            end
        end
    end

    // decode stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    // video ram
    hcbd_ram #(
        .DEPTH (VRAM_BYTES),
        .WIDTH (8),
        .AW    (VRAM_AW)
    ) u_vram (
        .clk   (clk),
        .we    (accept && is_write && region == hcbd_pkg::REGION_VRAM),
        .re    (accept && !is_write && region == hcbd_pkg::REGION_VRAM),
        .addr  (address[VRAM_AW-1:0]),
        .wdata (write_data),
        .rdata (vram_q)
    );

    // work ram
    hcbd_ram #(
        .DEPTH (WORK_RAM_BYTES),
        .WIDTH (8),
        .AW    (WRAM_AW)
    ) u_wram (
        .clk   (clk),
        .we    (accept && is_write && region == hcbd_pkg::REGION_WRAM),
        .re    (accept && !is_write && region == hcbd_pkg::REGION_WRAM),
        .addr  (address[WRAM_AW-1:0]),
        .wdata (write_data),
        .rdata (wram_q)
    );

    // high ram
    hcbd_ram #(
        .DEPTH (HRAM_BYTES),
        .WIDTH (8),
        .AW    (HRAM_AW)
    ) u_hram (
        .clk   (clk),
        .we    (accept && is_write && region == hcbd_pkg::REGION_HRAM),
        .re    (accept && !is_write && region == hcbd_pkg::REGION_HRAM),
        .addr  (address[HRAM_AW-1:0]),
        .wdata (write_data),
        .rdata (hram_q)
    );

    // i/o registers: the line counter stores zero, the dma register ignores writes
    assign io_we    = accept && is_write && region == hcbd_pkg::REGION_IO
                      && address != ADDR_DMA;
    assign io_wdata = (address == ADDR_LY) ? 8'h00 : write_data;

    hcbd_io_file u_io (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (io_we),
        .re    (accept && !is_write && region == hcbd_pkg::REGION_IO),
        .addr  (address[6:0]),
        .wdata (io_wdata),
        .rdata (io_q)
    );

    // result select and output register
    hcbd_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .stage    (stage_reg),
        .vram_q   (vram_q),
        .wram_q   (wram_q),
        .io_q     (io_q),
        .hram_q   (hram_q),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // input stalls only while the decode stage is full
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> stage_valid_reg)
        else $error("input stalled with empty decode stage");

    // a decoded item moved on always lands in the result register
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced item missing from result register");

    // unmapped accesses never return data
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == hcbd_pkg::REGION_NONE) |-> m_tdata == 8'h00)
        else $error("unmapped access returned data");

    // interrupt enable write takes the written byte
    a_ie_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_write && address == 16'hffff) |=> ie_reg == $past(write_data))
        else $error("interrupt enable write lost");
`endif

endmodule
